// ===== rtl/bfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and helpers of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W    = 32;
  localparam int RC_W      = 16;
  localparam int CNT_W     = 13;
  localparam int WORD_W    = 64;   // bitmap word, frames per word
  localparam int BIT_W     = 6;    // bit index within a bitmap word
  localparam int CFG_IDX_W = 2;

  localparam logic [RC_W-1:0] RC_SAT = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd1;

  typedef enum logic [2:0] {
    OP_ALLOC     = 3'd0,
    OP_FREE      = 3'd1,
    OP_REF_INC   = 3'd2,
    OP_REF_READ  = 3'd3,
    OP_MARK_USED = 3'd4,
    OP_MARK_FREE = 3'd5
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ALLOC_RD,
    ST_ALLOC_MOD,
    ST_POINT_RD,
    ST_POINT_MOD,
    ST_RANGE_RD,
    ST_RANGE_MOD,
    ST_RANGE_RC,
    ST_DONE
  } state_e;

  // {found, index} of the lowest set bit
  function automatic logic [BIT_W:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, BIT_W'(i)};
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/bfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfa_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/bitmap_frame_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// Physical frame allocator: used/free bitmap plus 16-bit refcounts per frame.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: tuser carries the operation, tdata the address and end
//    address. One result word per input word on the output stream.
//  - Config channel: index 0 base address, 1 frame count. A write to either
//    reinitialises the map (all frames used, counts zero) by a clearing pass
//    over all MAX_FRAME_SLOTS slots; other indexes are accepted and ignored.
//    Write config only while the block is idle.
//  - Reset: same clearing pass, input tready low.
//  - One item at a time. From accept an item passes a decode state, then:
//      ignored / empty ops : straight to the done state
//      refcount / free ops : a point read state, then a point modify state
//      alloc               : a read and a modify state per bitmap word scanned
//      range ops           : per word touched read, modify, then one refcount
//        step per frame changed and a last step; words = MAX_FRAME_SLOTS/64;
//    the single-ported bitmap read, with a read-modify-write turn, sets the scan time.
//  - Output register: the next item is taken while a result waits; if the
//    receiver stalls, the following result holds in the done state.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int MAX_FRAME_SLOTS = 4096,
  parameter int FRAME_SHIFT     = 12
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [63:0]                    s_axis_tdata,  // address, end_address
  input  logic [2:0]                     s_axis_tuser,  // operation
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_address, refcount_value, free_count, used_count, zero pad
  output logic [79:0]                    m_axis_tdata,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bfa_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [31:0]                    cfg_data_i
);

  import bfa_pkg::*;

  localparam int FIW   = $clog2(MAX_FRAME_SLOTS);
  localparam int WORDS = (MAX_FRAME_SLOTS + WORD_W - 1) / WORD_W;
  localparam int WIW   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NA    = (FIW > CNT_W) ? FIW : CNT_W;
  localparam int NW    = ((NA > WIW + BIT_W) ? NA : WIW + BIT_W) + 1;
  localparam logic [32:0]    LOW_MASK  = 33'((64'd1 << FRAME_SHIFT) - 64'd1);
  localparam logic [32:0]    TOP_ADDR  = 33'h1_0000_0000;
  localparam logic [32:0]    MAX33     = 33'(MAX_FRAME_SLOTS);
  localparam logic [FIW-1:0] CLR_LAST  = FIW'(MAX_FRAME_SLOTS - 1);
  localparam logic [WIW-1:0] WORD_LAST = WIW'(WORDS - 1);

  state_e state_q, state_d;

  // config
  logic [31:0]      base_q, base_d;
  logic [CNT_W-1:0] fcount_q, fcount_d;
  logic [CNT_W-1:0] lim_q;

  // item
  logic [2:0]       op_q, op_d;
  logic [31:0]      addr_q, addr_d, eaddr_q, eaddr_d;
  logic [NW-1:0]    f_q, f_d, sf_q, sf_d, ef_q, ef_d;
  logic [WIW-1:0]   w_q, w_d, last_q, last_d;
  logic [WORD_W-1:0] pend_q, pend_d;
  logic [CNT_W-1:0] free_q, free_d;
  logic [31:0]      res_q, res_d;
  logic [RC_W-1:0]  rcv_q, rcv_d;
  logic [FIW-1:0]   clr_q, clr_d;

  // result register
  logic        m_valid_q, m_valid_d;
  logic [79:0] m_data_q, m_data_d;

  // memories
  logic              bm_we;
  logic [WIW-1:0]    bm_waddr, bm_raddr;
  logic [WORD_W-1:0] bm_wdata, bm_rdata;
  logic              rc_we;
  logic [FIW-1:0]    rc_waddr, rc_raddr;
  logic [RC_W-1:0]   rc_wdata, rc_rdata;

  bfa_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (bm_we),
    .waddr_i(bm_waddr),
    .wdata_i(bm_wdata),
    .raddr_i(bm_raddr),
    .rdata_o(bm_rdata)
  );

  bfa_ram #(.WIDTH(RC_W), .DEPTH(MAX_FRAME_SLOTS)) u_refcnt (
    .clk_i  (clk_i),
    .we_i   (rc_we),
    .waddr_i(rc_waddr),
    .wdata_i(rc_wdata),
    .raddr_i(rc_raddr),
    .rdata_o(rc_rdata)
  );

  // handshakes
  logic s_acc, cfg_acc, cfg_hit, can_load;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = (state_q == ST_IDLE) && !s_axis_tvalid;
  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign cfg_hit  = cfg_acc && (cfg_index_i == CFG_BASE_ADDRESS ||
                                cfg_index_i == CFG_FRAME_COUNT);
  assign can_load = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // managed window
  logic [32:0] ms33, me33, fit33, l1;
  assign ms33  = {1'b0, base_q} & ~LOW_MASK;
  assign fit33 = (TOP_ADDR - ms33) >> FRAME_SHIFT;
  assign l1    = ({20'd0, fcount_q} < MAX33) ? {20'd0, fcount_q} : MAX33;
  assign me33  = ms33 + ({20'd0, lim_q} << FRAME_SHIFT);

  // decode of the latched item
  logic [32:0]   a33, off33, s33, e33, sc33, ec33;
  logic          in_rng, free_ok, rng_ok;
  logic [NW-1:0] sf_nw, ef_nw, ef_m1;
  always_comb begin
    a33     = {1'b0, addr_q};
    off33   = a33 - ms33;
    in_rng  = (a33 >= ms33) && ((off33 >> FRAME_SHIFT) < {20'd0, lim_q});
    free_ok = (addr_q != '0) && ((a33 & LOW_MASK) == '0) && in_rng;
    if (op_q == OP_MARK_USED) begin
      s33 = a33 & ~LOW_MASK;
      e33 = ({1'b0, eaddr_q} + LOW_MASK) & ~LOW_MASK;
    end else begin
      s33 = (a33 + LOW_MASK) & ~LOW_MASK;
      e33 = {1'b0, eaddr_q} & ~LOW_MASK;
    end
    sc33   = (s33 < ms33) ? ms33 : s33;
    ec33   = (e33 > me33) ? me33 : e33;
    rng_ok = sc33 < ec33;
    sf_nw  = NW'((sc33 - ms33) >> FRAME_SHIFT);
    ef_nw  = NW'((ec33 - ms33) >> FRAME_SHIFT);
    ef_m1  = ef_nw - NW'(1);
  end

  // bitmap word helpers
  logic [BIT_W:0]    alloc_hit, pend_hit;
  logic [WORD_W-1:0] avail, lo_mask, hi_mask, rmask, changed;
  logic [NW-1:0]     wbase;
  logic [6:0]        hi;
  logic              bit_used;
  logic [RC_W-1:0]   rc_dec;
  always_comb begin
    avail = ~bm_rdata;
    if (w_q == '0) begin
      avail[0] = 1'b0;  // frame 0 is never handed out
    end
    alloc_hit = lowest_set(avail);
    pend_hit  = lowest_set(pend_q);
    wbase   = NW'({w_q, BIT_W'(0)});
    hi      = (w_q == last_q) ? 7'(ef_q - wbase) : 7'd64;
    lo_mask = {WORD_W{1'b1}} << ((wbase <= sf_q) ? sf_q[BIT_W-1:0] : BIT_W'(0));
    hi_mask = {WORD_W{1'b1}} >> (7'd64 - hi);
    rmask   = lo_mask & hi_mask;
    if (op_q == OP_MARK_USED) begin
      changed = rmask & ~bm_rdata;
    end else begin
      changed = rmask & bm_rdata;
      if (w_q == '0) begin
        changed[0] = 1'b0;  // range free never releases frame 0
      end
    end
    bit_used = bm_rdata[f_q[BIT_W-1:0]];
    rc_dec   = (rc_rdata != '0) ? rc_rdata - RC_W'(1) : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (clr_q == CLR_LAST) state_d = ST_IDLE;
      ST_IDLE: begin
        if (cfg_hit) state_d = ST_CLEAR;
        else if (s_acc) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (op_q)
          OP_ALLOC:     state_d = (free_q != '0) ? ST_ALLOC_RD : ST_DONE;
          OP_FREE:      state_d = free_ok ? ST_POINT_RD : ST_DONE;
          OP_REF_INC,
          OP_REF_READ:  state_d = in_rng ? ST_POINT_RD : ST_DONE;
          OP_MARK_USED,
          OP_MARK_FREE: state_d = rng_ok ? ST_RANGE_RD : ST_DONE;
          default:      state_d = ST_DONE;
        endcase
      end
      ST_ALLOC_RD:  state_d = ST_ALLOC_MOD;
      ST_ALLOC_MOD: begin
        if (alloc_hit[BIT_W] || w_q == last_q) state_d = ST_DONE;
        else state_d = ST_ALLOC_RD;
      end
      ST_POINT_RD:  state_d = ST_POINT_MOD;
      ST_POINT_MOD: state_d = ST_DONE;
      ST_RANGE_RD:  state_d = ST_RANGE_MOD;
      ST_RANGE_MOD: state_d = ST_RANGE_RC;
      ST_RANGE_RC: begin
        if (pend_q == '0) state_d = (w_q == last_q) ? ST_DONE : ST_RANGE_RD;
      end
      ST_DONE:      if (can_load) state_d = ST_IDLE;
      default:      state_d = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    base_d    = base_q;
    fcount_d  = fcount_q;
    op_d      = op_q;
    addr_d    = addr_q;
    eaddr_d   = eaddr_q;
    f_d       = f_q;
    sf_d      = sf_q;
    ef_d      = ef_q;
    w_d       = w_q;
    last_d    = last_q;
    pend_d    = pend_q;
    free_d    = free_q;
    res_d     = res_q;
    rcv_d     = rcv_q;
    clr_d     = clr_q;
    m_data_d  = m_data_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    bm_we     = 1'b0;
    bm_waddr  = w_q;
    bm_wdata  = bm_rdata;
    bm_raddr  = w_q;
    rc_we     = 1'b0;
    rc_waddr  = f_q[FIW-1:0];
    rc_wdata  = '0;
    rc_raddr  = f_q[FIW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        rc_we    = 1'b1;
        rc_waddr = clr_q;
        bm_we    = NW'(clr_q) < NW'(WORDS);
        bm_waddr = WIW'(clr_q);
        bm_wdata = '1;
        clr_d    = clr_q + FIW'(1);
        free_d   = '0;
      end
      ST_IDLE: begin
        clr_d = '0;
        if (cfg_acc) begin
          if (cfg_index_i == CFG_BASE_ADDRESS) base_d = cfg_data_i;
          if (cfg_index_i == CFG_FRAME_COUNT)  fcount_d = cfg_data_i[CNT_W-1:0];
        end else if (s_acc) begin
          op_d    = s_axis_tuser;
          addr_d  = s_axis_tdata[31:0];
          eaddr_d = s_axis_tdata[63:32];
          res_d   = '0;
          rcv_d   = '0;
        end
      end
      ST_DECODE: begin
        f_d  = NW'(off33 >> FRAME_SHIFT);
        sf_d = sf_nw;
        ef_d = ef_nw;
        if (op_q == OP_ALLOC) begin
          w_d    = '0;
          last_d = WORD_LAST;
        end else begin
          w_d    = WIW'(sf_nw >> BIT_W);
          last_d = WIW'(ef_m1 >> BIT_W);
        end
      end
      ST_ALLOC_MOD: begin
        if (alloc_hit[BIT_W]) begin
          bm_we    = 1'b1;
          bm_wdata = bm_rdata | (WORD_W'(1) << alloc_hit[BIT_W-1:0]);
          rc_we    = 1'b1;
          rc_waddr = FIW'({w_q, alloc_hit[BIT_W-1:0]});
          rc_wdata = RC_W'(1);
          free_d   = free_q - CNT_W'(1);
          res_d    = 32'(ms33 + (33'({w_q, alloc_hit[BIT_W-1:0]}) << FRAME_SHIFT));
        end else begin
          w_d = w_q + WIW'(1);
        end
      end
      ST_POINT_RD: begin
        bm_raddr = WIW'(f_q >> BIT_W);
      end
      ST_POINT_MOD: begin
        bm_waddr = WIW'(f_q >> BIT_W);
        if (op_q == OP_FREE) begin
          if (bit_used) begin
            rc_we    = 1'b1;
            rc_wdata = rc_dec;
            if (rc_dec == '0) begin
              bm_we    = 1'b1;
              bm_wdata = bm_rdata & ~(WORD_W'(1) << f_q[BIT_W-1:0]);
              free_d   = free_q + CNT_W'(1);
            end
          end
        end else if (op_q == OP_REF_INC) begin
          rc_we    = rc_rdata != RC_SAT;
          rc_wdata = rc_rdata + RC_W'(1);
        end else begin
          rcv_d = rc_rdata;
        end
      end
      ST_RANGE_MOD: begin
        bm_we  = 1'b1;
        pend_d = changed;
        if (op_q == OP_MARK_USED) bm_wdata = bm_rdata | changed;
        else bm_wdata = bm_rdata & ~changed;
      end
      ST_RANGE_RC: begin
        if (pend_q != '0) begin
          rc_we    = 1'b1;
          rc_waddr = FIW'({w_q, pend_hit[BIT_W-1:0]});
          pend_d   = pend_q & ~(WORD_W'(1) << pend_hit[BIT_W-1:0]);
          if (op_q == OP_MARK_USED) begin
            rc_wdata = RC_W'(1);
            free_d   = free_q - CNT_W'(1);
          end else begin
            free_d   = free_q + CNT_W'(1);
          end
        end else begin
          w_d = w_q + WIW'(1);
        end
      end
      ST_DONE: begin
        if (can_load) begin
          m_valid_d = 1'b1;
          m_data_d  = {6'd0, lim_q - free_q, free_q, rcv_q, res_q};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      base_q    <= '0;
      fcount_q  <= '0;
      lim_q     <= '0;
      free_q    <= '0;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      base_q    <= base_d;
      fcount_q  <= fcount_d;
      lim_q     <= CNT_W'((l1 < fit33) ? l1 : fit33);
      free_q    <= free_d;
      clr_q     <= clr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    addr_q   <= addr_d;
    eaddr_q  <= eaddr_d;
    f_q      <= f_d;
    sf_q     <= sf_d;
    ef_q     <= ef_d;
    w_q      <= w_d;
    last_q   <= last_d;
    pend_q   <= pend_d;
    res_q    <= res_d;
    rcv_q    <= rcv_d;
    m_data_q <= m_data_d;
  end

endmodule
